FILE: design/resp_stream_parser_assert.svh
// Assertion macros shared by the checker of the RESP stream parser.
`ifndef RESP_STREAM_PARSER_ASSERT_SVH
`define RESP_STREAM_PARSER_ASSERT_SVH

// Assert an implication that holds in the same cycle.
`define RSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("resp_stream_parser: check failed");

// Assert an implication that holds in the next cycle.
`define RSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("resp_stream_parser: check failed");

`endif

FILE: design/rsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

	// Parser phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LINE,
		PH_INT,
		PH_LEN,
		PH_DATA,
		PH_TAIL,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		VT_SIMPLE,
		VT_ERROR,
		VT_BULK,
		VT_INT,
		VT_ARRAY
	} vtype_t;

	typedef enum logic [1:0] {
		K_PAYLOAD,
		K_HEADER,
		K_END,
		K_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		E_INCOMPLETE,
		E_INVALID,
		E_UNSUPPORTED,
		E_LIMIT
	} err_t;

	// Stream characters
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Integer line flag bits
	localparam int IF_ANY   = 0;
	localparam int IF_SIGN  = 1;
	localparam int IF_NEG   = 2;
	localparam int IF_DIGIT = 3;
	localparam int IF_BAD   = 4;

	// Length line flag bits
	localparam int LF_DIGIT = 0;
	localparam int LF_STOP  = 1;
	localparam int LF_OVER  = 2;

	// Result word queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PW    = 2;

	typedef struct packed {
		kind_t       kind;
		vtype_t      vtype;
		logic [7:0]  pbyte;
		logic [32:0] num;
		logic [3:0]  depth;
		logic [3:0]  closed;
		logic        done;
		err_t        code;
		logic        last;
	} result_t;

	// Decoded work of one input word
	typedef struct packed {
		logic        hdr;
		logic        err;
		vtype_t      err_type;
		err_t        err_code;
		logic        pay0;
		logic [7:0]  pay0_b;
		logic        pay1;
		logic [7:0]  pay1_b;
		logic        fin;
		logic        push;
		logic [32:0] num;
		logic        inc;
	} act_t;

endpackage

`default_nettype wire

FILE: design/resp_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// RESP byte stream parser.
// Input channel s_*: one stream byte per word in s_tdata; s_tlast marks the last
// byte currently available, and a value left open there is reported incomplete.
// Output channel m_*: event words. m_tuser is the event kind (payload byte,
// value header, value end, error); m_tdata carries type, byte, number, nesting
// depth, closed array count, message done and error code; m_tlast marks the
// final word caused by one input byte.
// Each byte is parsed combinationally against the registered parser state; its
// zero, one or two words enter a four-word result queue when the byte is
// accepted, and m_* shows the oldest word held in the queue.
// Throughput: one byte per cycle while each byte yields at most one word and
// the receiver takes every word; a byte that yields two words puts both on the
// output in turn. s_tready is high while the result queue has at least two free slots.
// Nested array counts live in a DEPTH-entry stack; closing a run of arrays is
// resolved in the same cycle from per-entry "one left" flags.
// Reset puts the parser at top level awaiting a type prefix and empties the
// queue. When the receiver stalls, the queue fills and then s_tready drops;
// no word is lost or reordered.
// After an error, bytes are dropped up to and including the next s_tlast byte.
module resp_stream_parser
	import rsp_pkg::*;
#(
	parameter int DEPTH       = 8,
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // end_of_buffer
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [2:0] value_type, [10:3] payload_byte, [43:11] number_value,
	// [47:44] nesting_depth, [51:48] closed_arrays, [52] message_done,
	// [54:53] error_code, [55] zero
	output logic [55:0]      m_tdata,
	output logic [1:0]       m_tuser,   // event_kind
	output logic             m_tlast    // last_of_run
);

	localparam int ACC_W = (LENGTH_BITS > 33) ? LENGTH_BITS : 33;
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ACC_W+3:0] LEN_MAX = (ACC_W + 4)'({LENGTH_BITS{1'b1}});

	// Parser state
	phase_t                 ph_q, ph_n;
	vtype_t                 ctype_q, ctype_n;
	logic                   held_q, held_n;
	logic [ACC_W-1:0]       acc_q, acc_n;
	logic [4:0]             flg_q, flg_n;
	logic [LENGTH_BITS-1:0] left_q, left_n;
	logic [LW-1:0]          lvl_q, lvl_n;
	logic [LENGTH_BITS-1:0] stk_q [DEPTH];
	logic                   one_q [DEPTH];

	// Work of the current byte
	act_t                   act;
	logic                   s_fire;
	logic [7:0]             b;
	logic                   en1, en2, en, line_end;
	logic [7:0]             ch;
	logic [ACC_W+4:0]       stp;
	logic [LW-1:0]          closed_c, lvl_after;
	logic [LW-1:0]          lvl_pre;
	logic                   stop;
	logic [IW-1:0]          dec_idx;
	logic [LENGTH_BITS-1:0] dec_src;
	result_t                res_c [2];
	result_t                cand;
	logic [1:0]             nres;

	// Result queue
	result_t                rq_q [RQ_DEPTH];
	logic [RQ_PW-1:0]       wp_q, rp_q;
	logic [RQ_PW:0]         cnt_q;
	logic                   m_fire;

	// One integer-line content byte
	function automatic logic [ACC_W+4:0] int_step(input logic [4:0] f,
			input logic [ACC_W-1:0] a, input logic [7:0] c);
		logic [4:0]       nf;
		logic [ACC_W-1:0] na;
		logic [35:0]      v;
		logic             taken;
		nf = f;
		na = a;
		v = '0;
		taken = 1'b0;
		if (!nf[IF_ANY]) begin
			nf[IF_ANY] = 1'b1;
			if (c == CH_PLUS) taken = 1'b1;
		end
		if (!taken && !nf[IF_SIGN]) begin
			nf[IF_SIGN] = 1'b1;
			if (c == CH_MINUS) begin
				nf[IF_NEG] = 1'b1;
				taken = 1'b1;
			end
		end
		if (!taken) begin
			if (c < CH_ZERO || c > CH_NINE) begin
				nf[IF_BAD] = 1'b1;
			end else begin
				nf[IF_DIGIT] = 1'b1;
				v = ({3'b0, a[32:0]} << 3) + ({3'b0, a[32:0]} << 1)
					+ 36'(c - CH_ZERO);
				if (v > 36'd2147483648) nf[IF_BAD] = 1'b1;
				else na[32:0] = v[32:0];
			end
		end
		return {nf, na};
	endfunction

	// One length-line content byte
	function automatic logic [ACC_W+4:0] len_step(input logic [4:0] f,
			input logic [ACC_W-1:0] a, input logic [7:0] c);
		logic [4:0]       nf;
		logic [ACC_W-1:0] na;
		logic [ACC_W+3:0] w;
		nf = f;
		na = a;
		w = '0;
		if (!nf[LF_STOP] && !nf[LF_OVER]) begin
			if (c < CH_ZERO || c > CH_NINE) begin
				nf[LF_STOP] = 1'b1;
			end else begin
				nf[LF_DIGIT] = 1'b1;
				w = ({4'b0, a} << 3) + ({4'b0, a} << 1) + (ACC_W + 4)'(c - CH_ZERO);
				if (w > LEN_MAX) nf[LF_OVER] = 1'b1;
				else na = w[ACC_W-1:0];
			end
		end
		return {nf, na};
	endfunction

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;
	assign b = s_tdata;

	// Count the arrays that a value end closes
	always_comb begin
		closed_c = '0;
		stop = 1'b0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (LW'(i) < lvl_q) begin
				if (!stop && one_q[i]) closed_c = closed_c + LW'(1);
				else stop = 1'b1;
			end
		end
		lvl_after = lvl_q - closed_c;
		dec_idx = IW'(lvl_after - LW'(1));
		dec_src = stk_q[dec_idx];
	end

	// Next state and decoded work
	always_comb begin
		ph_n = ph_q;
		ctype_n = ctype_q;
		held_n = held_q;
		acc_n = acc_q;
		flg_n = flg_q;
		left_n = left_q;
		lvl_n = lvl_q;
		act = '0;
		ch = CH_CR;
		en = 1'b0;
		stp = '0;
		line_end = held_q && (b == CH_LF);
		en1 = held_q && (b != CH_LF);
		en2 = !line_end && (b != CH_CR);
		unique case (ph_q)
			PH_IDLE: begin
				act.hdr = 1'b1;
				unique case (b)
					CH_PLUS: begin
						ctype_n = VT_SIMPLE;
						ph_n = PH_LINE;
					end
					CH_MINUS: begin
						ctype_n = VT_ERROR;
						ph_n = PH_LINE;
					end
					CH_DOLLAR: begin
						ctype_n = VT_BULK;
						ph_n = PH_LEN;
					end
					CH_COLON: begin
						ctype_n = VT_INT;
						ph_n = PH_INT;
					end
					CH_STAR: begin
						ctype_n = VT_ARRAY;
						ph_n = PH_LEN;
					end
					default: begin
						act.hdr = 1'b0;
						act.err = 1'b1;
						act.err_type = VT_SIMPLE;
						act.err_code = E_UNSUPPORTED;
						ph_n = PH_DRAIN;
					end
				endcase
				held_n = 1'b0;
				if (act.hdr) begin
					acc_n = '0;
					flg_n = '0;
					left_n = '0;
				end
			end
			PH_DATA: begin
				act.pay0 = 1'b1;
				act.pay0_b = b;
				left_n = left_q - LENGTH_BITS'(1);
				if (left_n == '0) ph_n = PH_TAIL;
			end
			PH_LINE, PH_INT, PH_LEN, PH_TAIL: begin
				held_n = (b == CH_CR);
				// Held CR first, then this byte
				for (int k = 0; k < 2; k++) begin
					ch = (k == 0) ? CH_CR : b;
					en = (k == 0) ? en1 : en2;
					if (en) begin
						priority if (ph_q == PH_LINE) begin
							if (!act.pay0) begin
								act.pay0 = 1'b1;
								act.pay0_b = ch;
							end else begin
								act.pay1 = 1'b1;
								act.pay1_b = ch;
							end
						end else if (ph_q == PH_INT) begin
							stp = int_step(flg_n, acc_n, ch);
							flg_n = stp[ACC_W+4:ACC_W];
							acc_n = stp[ACC_W-1:0];
						end else if (ph_q == PH_LEN) begin
							stp = len_step(flg_n, acc_n, ch);
							flg_n = stp[ACC_W+4:ACC_W];
							acc_n = stp[ACC_W-1:0];
						end else begin
							stp = '0;
						end
					end
				end
				// CR LF closes the line
				if (line_end) begin
					unique case (ph_q)
						PH_LINE: begin
							act.fin = 1'b1;
							act.num = '0;
						end
						PH_INT: begin
							if (flg_q[IF_BAD] || !flg_q[IF_DIGIT] ||
								(!flg_q[IF_NEG] && acc_q[32:0] > 33'd2147483647)) begin
								act.err = 1'b1;
								act.err_code = E_INVALID;
							end else begin
								act.fin = 1'b1;
								act.num = flg_q[IF_NEG] ? (33'd0 - acc_q[32:0]) : acc_q[32:0];
							end
						end
						PH_LEN: begin
							if (!flg_q[LF_DIGIT]) begin
								act.err = 1'b1;
								act.err_code = E_INVALID;
							end else if (flg_q[LF_OVER]) begin
								act.err = 1'b1;
								act.err_code = E_LIMIT;
							end else if (ctype_q == VT_BULK) begin
								left_n = acc_q[LENGTH_BITS-1:0];
								ph_n = (acc_q == '0) ? PH_TAIL : PH_DATA;
							end else if (acc_q == '0) begin
								act.fin = 1'b1;
								act.num = '0;
							end else if (lvl_q >= LW'(DEPTH)) begin
								act.err = 1'b1;
								act.err_code = E_LIMIT;
							end else begin
								act.push = 1'b1;
								act.num = acc_q[32:0];
								lvl_n = lvl_q + LW'(1);
								ph_n = PH_IDLE;
							end
						end
						default: begin
							act.fin = 1'b1;
							act.num = acc_q[32:0];
						end
					endcase
					if (act.err) begin
						act.err_type = ctype_q;
						ph_n = PH_DRAIN;
						held_n = 1'b0;
					end
					if (act.fin) begin
						lvl_n = lvl_after;
						ph_n = PH_IDLE;
					end
				end
			end
			PH_DRAIN: begin
				held_n = held_q;
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase
		// Nesting level after this byte's work, before any end-of-buffer reset
		lvl_pre = lvl_n;
		// End of buffer: report an open value, return to top level
		if (s_tlast) begin
			if (!act.err && ph_q != PH_DRAIN && (ph_n != PH_IDLE || lvl_n != '0))
				act.inc = 1'b1;
			ph_n = PH_IDLE;
			lvl_n = '0;
			held_n = 1'b0;
		end
	end

	// Assemble the result words of this byte
	always_comb begin
		res_c[0] = '0;
		res_c[1] = '0;
		nres = '0;
		cand = '0;
		cand.depth = 4'(lvl_q);
		if (act.hdr) begin
			cand.kind = K_HEADER;
			cand.vtype = ctype_n;
			res_c[nres[0]] = cand;
			nres = nres + 2'd1;
		end
		if (act.err) begin
			cand = '0;
			cand.depth = 4'(lvl_q);
			cand.kind = K_ERROR;
			cand.vtype = act.err_type;
			cand.code = act.err_code;
			res_c[nres[0]] = cand;
			nres = nres + 2'd1;
		end
		if (act.pay0) begin
			cand = '0;
			cand.depth = 4'(lvl_q);
			cand.kind = K_PAYLOAD;
			cand.vtype = ctype_q;
			cand.pbyte = act.pay0_b;
			res_c[nres[0]] = cand;
			nres = nres + 2'd1;
		end
		if (act.pay1 && nres < 2'd2) begin
			cand = '0;
			cand.depth = 4'(lvl_q);
			cand.kind = K_PAYLOAD;
			cand.vtype = ctype_q;
			cand.pbyte = act.pay1_b;
			res_c[nres[0]] = cand;
			nres = nres + 2'd1;
		end
		if ((act.fin || act.push) && nres < 2'd2) begin
			cand = '0;
			cand.depth = 4'(lvl_q);
			cand.kind = K_END;
			cand.vtype = ctype_q;
			cand.num = act.num;
			cand.closed = act.fin ? 4'(closed_c) : 4'd0;
			cand.done = act.fin && (lvl_after == '0);
			res_c[nres[0]] = cand;
			nres = nres + 2'd1;
		end
		if (act.inc) begin
			// Drop payload words, keep header or value end
			if (nres != 2'd0 && res_c[0].kind == K_PAYLOAD) nres = 2'd0;
			cand = '0;
			cand.depth = 4'(lvl_pre);
			cand.kind = K_ERROR;
			cand.vtype = ctype_n;
			cand.code = E_INCOMPLETE;
			res_c[nres[0]] = cand;
			nres = nres + 2'd1;
		end
		if (nres != 2'd0) res_c[nres == 2'd2].last = 1'b1;
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			ctype_q <= VT_SIMPLE;
			held_q <= 1'b0;
			acc_q <= '0;
			flg_q <= '0;
			left_q <= '0;
			lvl_q <= '0;
		end else if (s_fire) begin
			ph_q <= ph_n;
			ctype_q <= ctype_n;
			held_q <= held_n;
			acc_q <= acc_n;
			flg_q <= flg_n;
			left_q <= left_n;
			lvl_q <= lvl_n;
		end
	end

	// Array count stack: push a new count, decrement the surviving top
	always_ff @(posedge clk) begin
		if (s_fire && act.push) begin
			stk_q[lvl_q[IW-1:0]] <= acc_q[LENGTH_BITS-1:0];
			one_q[lvl_q[IW-1:0]] <= (acc_q == ACC_W'(1));
		end
		if (s_fire && act.fin && lvl_after != '0) begin
			stk_q[dec_idx] <= dec_src - LENGTH_BITS'(1);
			one_q[dec_idx] <= (dec_src == LENGTH_BITS'(2));
		end
	end

	// Result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (s_fire) wp_q <= wp_q + RQ_PW'(nres);
			if (m_fire) rp_q <= rp_q + RQ_PW'(1);
			cnt_q <= cnt_q + (s_fire ? (RQ_PW + 1)'(nres) : '0)
				- (RQ_PW + 1)'(m_fire);
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (s_fire && nres != 2'd0) rq_q[wp_q] <= res_c[0];
		if (s_fire && nres == 2'd2) rq_q[wp_q + RQ_PW'(1)] <= res_c[1];
	end

	assign s_tready = cnt_q <= (RQ_PW + 1)'(RQ_DEPTH - 2);
	assign m_tvalid = cnt_q != '0;
	assign m_tdata = {1'b0, rq_q[rp_q].code, rq_q[rp_q].done, rq_q[rp_q].closed,
		rq_q[rp_q].depth, rq_q[rp_q].num, rq_q[rp_q].pbyte, rq_q[rp_q].vtype};
	assign m_tuser = rq_q[rp_q].kind;
	assign m_tlast = rq_q[rp_q].last;

endmodule

`default_nettype wire

FILE: design/rsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "resp_stream_parser_assert.svh"

module rsp_checker
	import rsp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// Conditions seen on the output side
	logic out_stall;
	logic is_pay;
	logic is_err;
	logic is_hdr;

	assign out_stall = m_tvalid && !m_tready;
	assign is_pay = m_tvalid && (m_tuser == K_PAYLOAD);
	assign is_err = m_tvalid && (m_tuser == K_ERROR);
	assign is_hdr = m_tvalid && (m_tuser == K_HEADER);

	// Hold a stalled output word
	`RSP_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable({m_tlast, m_tuser, m_tdata}))

	// Payload words carry no number, count, done or code
	`RSP_ASSERT_NOW(a_payload_clean, is_pay, m_tdata[43:11] == 33'd0 && m_tdata[55:48] == 8'd0)

	// An error is always the final word of its byte
	`RSP_ASSERT_NOW(a_error_last, is_err, m_tlast)

	// Headers report no number and close nothing
	`RSP_ASSERT_NOW(a_header_clean, is_hdr, m_tdata[43:11] == 33'd0 && m_tdata[54:48] == 7'd0)

	// Input stalls only while words wait on the output
	`RSP_ASSERT_NOW(a_stall_full, !s_tready, m_tvalid)

endmodule

bind resp_stream_parser rsp_checker u_rsp_checker (.*);

`default_nettype wire

FILE: bench/resp_event_checker.sv
`timescale 1ns / 1ps

// Watch both channels, predict event words from accepted stream bytes and
// compare them in order against the words the parser emits.
module resp_event_checker
	import rsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          words_checked
);

	localparam int STACK_DEPTH = 8;
	localparam logic [63:0] MAX_LEN = 64'hFFFF_FFFF;

	// predicted parser state
	phase_t      phase;
	vtype_t      cur_type;
	bit          held_cr;
	logic [63:0] digits;
	logic [4:0]  nflags;
	logic [63:0] bytes_left;
	logic [63:0] counts [STACK_DEPTH];
	int          level;

	// words caused by the current byte
	result_t     evs [2];
	int          nev;
	bit          err_now;
	result_t     expected_words [$];

	function automatic void add_event(kind_t k, vtype_t t, logic [7:0] b, logic [63:0] num,
			int closed, bit done, err_t code);
		if (nev < 2) begin
			evs[nev].kind = k;
			evs[nev].vtype = t;
			evs[nev].pbyte = b;
			evs[nev].num = num[32:0];
			evs[nev].depth = level[3:0];
			evs[nev].closed = closed[3:0];
			evs[nev].done = done;
			evs[nev].code = code;
			evs[nev].last = 1'b0;
			nev++;
		end
	endfunction

	function automatic void raise_error(vtype_t t, err_t code);
		add_event(K_ERROR, t, 8'h00, 64'd0, 0, 1'b0, code);
		phase = PH_DRAIN;
		held_cr = 0;
		err_now = 1;
	endfunction

	function automatic void return_to_top();
		phase = PH_IDLE;
		level = 0;
		held_cr = 0;
	endfunction

	// Pop every array that this value completes.
	function automatic void close_value(logic [63:0] num);
		int lv;
		int closed;
		logic [63:0] c;
		lv = level;
		closed = 0;
		while (lv > 0 && lv <= STACK_DEPTH) begin
			c = counts[lv-1] - 64'd1;
			counts[lv-1] = c;
			if (c != 0)
				break;
			lv--;
			closed++;
		end
		add_event(K_END, cur_type, 8'h00, num, closed, lv == 0, E_INCOMPLETE);
		level = lv;
		phase = PH_IDLE;
	endfunction

	function automatic void integer_char(logic [7:0] b);
		logic [63:0] v;
		if (!nflags[IF_ANY]) begin
			nflags[IF_ANY] = 1;
			if (b == CH_PLUS)
				return;
		end
		if (!nflags[IF_SIGN]) begin
			nflags[IF_SIGN] = 1;
			if (b == CH_MINUS) begin
				nflags[IF_NEG] = 1;
				return;
			end
		end
		if (b < CH_ZERO || b > CH_NINE) begin
			nflags[IF_BAD] = 1;
			return;
		end
		nflags[IF_DIGIT] = 1;
		v = digits * 64'd10 + 64'(b - CH_ZERO);
		if (v > 64'd2147483648)
			nflags[IF_BAD] = 1;
		else
			digits = v;
	endfunction

	function automatic void length_char(logic [7:0] b);
		logic [63:0] d;
		if (nflags[LF_STOP] || nflags[LF_OVER])
			return;
		if (b < CH_ZERO || b > CH_NINE) begin
			nflags[LF_STOP] = 1;
			return;
		end
		d = 64'(b - CH_ZERO);
		nflags[LF_DIGIT] = 1;
		if (digits > (MAX_LEN - d) / 64'd10)
			nflags[LF_OVER] = 1;
		else
			digits = digits * 64'd10 + d;
	endfunction

	function automatic void line_char(logic [7:0] b);
		case (phase)
			PH_LINE: add_event(K_PAYLOAD, cur_type, b, 64'd0, 0, 1'b0, E_INCOMPLETE);
			PH_INT:  integer_char(b);
			PH_LEN:  length_char(b);
			default: ;
		endcase
	endfunction

	// Resolve a CR LF according to the line being read.
	function automatic void line_done();
		bit neg;
		case (phase)
			PH_LINE: close_value(64'd0);
			PH_INT: begin
				neg = nflags[IF_NEG];
				if (nflags[IF_BAD] || !nflags[IF_DIGIT] || (!neg && digits > 64'd2147483647))
					raise_error(cur_type, E_INVALID);
				else
					close_value(neg ? 64'd0 - digits : digits);
			end
			PH_LEN: begin
				if (!nflags[LF_DIGIT])
					raise_error(cur_type, E_INVALID);
				else if (nflags[LF_OVER])
					raise_error(cur_type, E_LIMIT);
				else if (cur_type == VT_BULK) begin
					bytes_left = digits;
					phase = (digits == 0) ? PH_TAIL : PH_DATA;
				end else if (digits == 0)
					close_value(64'd0);
				else if (level >= STACK_DEPTH)
					raise_error(cur_type, E_LIMIT);
				else begin
					add_event(K_END, cur_type, 8'h00, digits, 0, 1'b0, E_INCOMPLETE);
					counts[level] = digits;
					level++;
					phase = PH_IDLE;
				end
			end
			PH_TAIL: close_value(digits);
			default: ;
		endcase
	endfunction

	function automatic void open_value(logic [7:0] b);
		case (b)
			CH_PLUS:   begin cur_type = VT_SIMPLE; phase = PH_LINE; end
			CH_MINUS:  begin cur_type = VT_ERROR;  phase = PH_LINE; end
			CH_DOLLAR: begin cur_type = VT_BULK;   phase = PH_LEN;  end
			CH_COLON:  begin cur_type = VT_INT;    phase = PH_INT;  end
			CH_STAR:   begin cur_type = VT_ARRAY;  phase = PH_LEN;  end
			default: begin
				raise_error(VT_SIMPLE, E_UNSUPPORTED);
				return;
			end
		endcase
		held_cr = 0;
		digits = 0;
		nflags = 0;
		bytes_left = 0;
		add_event(K_HEADER, cur_type, 8'h00, 64'd0, 0, 1'b0, E_INCOMPLETE);
	endfunction

	// Predict the words of one accepted byte and queue them.
	function automatic void parse_byte(logic [7:0] b, bit eob);
		bit ended;
		int k;
		nev = 0;
		err_now = 0;
		if (phase == PH_DRAIN) begin
			if (eob)
				return_to_top();
			return;
		end
		if (phase == PH_IDLE)
			open_value(b);
		else if (phase == PH_DATA) begin
			add_event(K_PAYLOAD, cur_type, b, 64'd0, 0, 1'b0, E_INCOMPLETE);
			bytes_left--;
			if (bytes_left == 0)
				phase = PH_TAIL;
		end else begin
			ended = 0;
			if (held_cr) begin
				held_cr = 0;
				if (b == CH_LF) begin
					line_done();
					ended = 1;
				end else
					line_char(CH_CR);
			end
			if (!ended) begin
				if (b == CH_CR)
					held_cr = 1;
				else
					line_char(b);
			end
		end
		// drop payload and report an open value at end of buffer
		if (eob) begin
			if (!err_now && (phase != PH_IDLE || level > 0)) begin
				k = 0;
				for (int i = 0; i < nev; i++)
					if (evs[i].kind != K_PAYLOAD) begin
						evs[k] = evs[i];
						k++;
					end
				nev = k;
				add_event(K_ERROR, cur_type, 8'h00, 64'd0, 0, 1'b0, E_INCOMPLETE);
			end
			return_to_top();
		end
		if (nev > 0)
			evs[nev-1].last = 1'b1;
		for (int i = 0; i < nev; i++)
			expected_words.insert(expected_words.size(), evs[i]);
	endfunction

	function automatic void report_field(string name, longint unsigned want, longint unsigned got);
		$display("%0t ns: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
	endfunction

	// Predict on input words, compare on output words.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			phase = PH_IDLE;
			cur_type = VT_SIMPLE;
			held_cr = 0;
			digits = 0;
			nflags = 0;
			bytes_left = 0;
			level = 0;
			for (int i = 0; i < STACK_DEPTH; i++)
				counts[i] = 0;
			expected_words.delete();
			fail_count <= 0;
			pending <= 0;
			words_checked <= 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.vtype = vtype_t'(m_tdata[2:0]);
				got.pbyte = m_tdata[10:3];
				got.num = m_tdata[43:11];
				got.depth = m_tdata[47:44];
				got.closed = m_tdata[51:48];
				got.done = m_tdata[52];
				got.code = err_t'(m_tdata[54:53]);
				got.last = m_tlast;
				if (expected_words.size() == 0) begin
					$display("%0t ns: unexpected word: expected none, actual %h / kind %0d",
						$time, m_tdata, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						if (got.kind !== want.kind) report_field("event kind", want.kind, got.kind);
						if (got.vtype !== want.vtype) report_field("value type", want.vtype, got.vtype);
						if (got.pbyte !== want.pbyte) report_field("payload byte", want.pbyte, got.pbyte);
						if (got.num !== want.num) report_field("number", want.num, got.num);
						if (got.depth !== want.depth) report_field("depth", want.depth, got.depth);
						if (got.closed !== want.closed) report_field("closed", want.closed, got.closed);
						if (got.done !== want.done) report_field("done", want.done, got.done);
						if (got.code !== want.code) report_field("error code", want.code, got.code);
						if (got.last !== want.last) report_field("last", want.last, got.last);
						fail_count <= fail_count + 1;
					end
				end
				words_checked <= words_checked + 1;
			end
			pending <= expected_words.size();
		end
	end

endmodule

FILE: bench/resp_stream_parser_tb.sv
`timescale 1ns / 1ps

module resp_stream_parser_tb;
	import rsp_pkg::*;

	localparam int TARGET_BYTES = 550;
	localparam int CALM_TAIL    = 80;
	localparam int QUIET_LIMIT  = 3000;
	localparam int LONG_HOLD    = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending;
	int words_checked;

	// stream bytes, bit 8 marks end of buffer
	logic [8:0] stream_q [$];
	int         sent;
	int         total;
	bit         calm;
	int         quiet;

	resp_stream_parser dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	resp_event_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending), .words_checked(words_checked)
	);

	initial clk = 0;
	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Append one stream byte, not yet marked as end of buffer.
	function automatic void put_byte(logic [7:0] b);
		stream_q.insert(stream_q.size(), {1'b0, b});
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	// Mark the last queued byte as the end of a buffer.
	function automatic void close_buffer();
		stream_q[stream_q.size()-1][8] = 1'b1;
	endfunction

	// Line content with no CR LF inside; bare CRs and LFs do occur.
	function automatic void put_line_body(int len);
		logic [7:0] b;
		logic [7:0] prev;
		prev = 8'h00;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0)
				b = 8'($urandom_range(0, 255));
			else
				b = 8'($urandom_range(8'h20, 8'h7E));
			if ($urandom_range(0, 9) == 0)
				b = CH_CR;
			if (prev == CH_CR && b == CH_LF)
				b = 8'h7A;
			put_byte(b);
			prev = b;
		end
	endfunction

	function automatic void put_number_line();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			put_text("12x4");
		else if (pick == 1)
			put_text("");
		else if (pick == 2)
			put_text("2147483648");
		else if (pick == 3)
			put_text("-2147483648");
		else if (pick == 4)
			put_text("+-7");
		else if (pick == 5)
			put_text("99999999999");
		else begin
			if ($urandom_range(0, 3) == 0)
				put_text("+");
			if ($urandom_range(0, 2) == 0)
				put_text("-");
			repeat ($urandom_range(1, 10))
				put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		put_text("\r\n");
	endfunction

	function automatic void put_bulk();
		int len;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			put_text("$4294967296\r\n");
			return;
		end
		if (pick == 1) begin
			put_text("$x\r\n");
			return;
		end
		len = $urandom_range(0, 5);
		put_text($sformatf("$%0d", len));
		if (pick < 5)
			put_text("ab");
		put_text("\r\n");
		repeat (len)
			put_byte(8'($urandom_range(0, 255)));
		if (pick > 16)
			put_text("q\r");
		put_text("\r\n");
	endfunction

	// One well-formed value with random content, occasionally broken.
	function automatic void put_value(int lvl);
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (lvl < 9 && pick < 25) begin
			n = (lvl >= 5) ? $urandom_range(0, 2) : $urandom_range(0, 3);
			put_text($sformatf("*%0d", n));
			if ($urandom_range(0, 9) == 0)
				put_text("z");
			put_text("\r\n");
			for (int i = 0; i < n; i++)
				put_value(lvl + 1);
		end else if (pick < 45) begin
			put_text(pick < 35 ? "+" : "-");
			put_line_body($urandom_range(0, 6));
			put_text("\r\n");
		end else if (pick < 70) begin
			put_text(":");
			put_number_line();
		end else if (pick < 97)
			put_bulk();
		else
			put_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_buffer();
		int pick;
		int start;
		int cut;
		pick = $urandom_range(0, 99);
		start = stream_q.size();
		if (pick < 10) begin
			// nested single-element arrays, some past the stack limit
			repeat ($urandom_range(5, 10))
				put_text("*1\r\n");
			put_value(9);
		end else if (pick < 18) begin
			repeat ($urandom_range(1, 8))
				put_byte(8'($urandom_range(0, 255)));
		end else
			repeat ($urandom_range(1, 3))
				put_value(0);
		// cut some buffers short
		if (pick >= 85 && stream_q.size() - start > 1) begin
			cut = start + $urandom_range(0, stream_q.size() - start - 2);
			while (stream_q.size() > cut + 1)
				void'(stream_q.pop_back());
		end
		close_buffer();
	endfunction

	// Sender
	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;
		sent = 0;
		calm = 0;
		// directed buffers
		put_text("+OK\r\n"); close_buffer();
		put_text("-a\rb\r\n"); close_buffer();
		put_text(":+-0\r\n:-2147483648\r\n"); close_buffer();
		put_text("$2xy\r\n\r\nzz\r\n*2\r\n:7\r\n*0\r\n"); close_buffer();
		put_text("?"); close_buffer();
		put_text("*3\r\n:1"); close_buffer();
		while (stream_q.size() < TARGET_BYTES)
			put_buffer();
		total = stream_q.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stream_q[i]) begin
			calm = (i > total - CALM_TAIL);
			if (!calm && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= stream_q[i][7:0];
			s_tlast <= stream_q[i][8];
			do
				@(posedge clk);
			while (!s_tready);
			sent++;
		end
		s_tvalid <= 1'b0;
		repeat (3) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d stream bytes in RESP buffers, nested, broken and noisy.", sent);
		$display("Checked %0d event words against the prediction.", words_checked);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Receiver: random stalls, one long hold-off, none near the end
	initial begin
		bit long_done;
		long_done = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if (!long_done && sent > 250) begin
				long_done = 1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				if (!calm) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 11)) @(posedge clk);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule

FILE: resp_stream_parser.f
+incdir+design
design/rsp_pkg.sv
design/resp_stream_parser.sv
design/rsp_checker.sv
bench/resp_event_checker.sv
bench/resp_stream_parser_tb.sv
